/* sv/ordered_list_engine_unit_assert.svh */
// assertion macros for the port-level checker
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OLIST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OLIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/olist_pkg.sv */
// package: defaults, operation and status codes of the ordered list engine
package olist_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOPOS    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

/* sv/ordered_list_engine_unit.sv */
// append, rejected insert and empty remove or dump go from decode straight to the result beat;
// insert shifts each entry from the tail down to the position up one slot, then writes the value;
// remove searches from the head, then shifts the entries behind the match down; dump emits
// each entry in turn. one item at a time: each search or shift step reads the entry ram, then
// uses or writes it; the next item is taken the cycle after its last beat is loaded.
// reset is synchronous: clears the entry count, sequencer and output valid; entries not cleared
module ordered_list_engine_unit #(
   parameter int CAPACITY   = olist_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = olist_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_has_entry,
   output logic               rsp_last,
   output logic [4:0]         rsp_length
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CmpW = (CW > 5) ? CW : 5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_FIN,
      S_REM_RD,
      S_REM_CMP,
      S_REM_SRD,
      S_REM_SWR,
      S_DMP_RD,
      S_DMP_EM,
      S_EMIT
   } state_type;

   state_type             state_ff;
   logic [1:0]            op_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [4:0]            pos_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [1:0]            status_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_entry_value_ff;
   logic                  rsp_has_entry_ff;
   logic                  rsp_last_ff;
   logic [4:0]            rsp_length_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CW-1:0]         rd_idx;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                  slot_free;
   logic                  emit_beat;
   logic                  is_full;
   logic [CmpW-1:0]       pos_ext;
   logic [CmpW-1:0]       cnt_ext;
   logic                  idx_is_tail;
   logic                  shift_done;

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_beat   = slot_free && (state_ff == S_DMP_EM || state_ff == S_EMIT);
   assign is_full     = (count_ff == CW'(CAPACITY));
   assign pos_ext     = CmpW'(pos_ff);
   assign cnt_ext     = CmpW'(count_ff);
   assign idx_is_tail = ((idx_ff + CW'(1)) == count_ff);
   assign shift_done  = ((idx_ff + CW'(2)) == count_ff);

   // read address: insert shifts pull from below, remove shifts pull from above
   always_comb begin
      case (state_ff)
         S_INS_RD:  rd_idx = idx_ff - CW'(1);
         S_REM_SRD: rd_idx = idx_ff + CW'(1);
         default:   rd_idx = idx_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      case (state_ff)
         S_DECODE: begin
            if (op_ff == olist_pkg::OP_APPEND && !is_full) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[AW-1:0];
               wr_data = val_ff;
            end
         end
         S_INS_WR:  wr_en = 1'b1;
         S_REM_SWR: wr_en = 1'b1;
         S_INS_FIN: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ext - CmpW'(1));
            wr_data = val_ff;
         end
         default:   wr_en = 1'b0;
      endcase
   end

   olist_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !emit_beat) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  val_ff   <= DATA_WIDTH'($unsigned(req_value));
                  pos_ff   <= req_position;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               case (op_ff)
                  olist_pkg::OP_APPEND: begin
                     idx_ff   <= '0;
                     state_ff <= S_EMIT;
                     if (is_full) begin
                        status_ff <= olist_pkg::ST_FULL;
                     end else begin
                        status_ff <= olist_pkg::ST_OK;
                        count_ff  <= count_ff + CW'(1);
                     end
                  end
                  olist_pkg::OP_INSERT: begin
                     if (pos_ff == 5'd0 || pos_ext > cnt_ext) begin
                        idx_ff    <= '0;
                        status_ff <= olist_pkg::ST_NOPOS;
                        state_ff  <= S_EMIT;
                     end else if (is_full) begin
                        idx_ff    <= '0;
                        status_ff <= olist_pkg::ST_FULL;
                        state_ff  <= S_EMIT;
                     end else begin
                        idx_ff    <= count_ff;
                        status_ff <= olist_pkg::ST_OK;
                        state_ff  <= S_INS_RD;
                     end
                  end
                  olist_pkg::OP_REMOVE: begin
                     idx_ff <= '0;
                     if (count_ff == '0) begin
                        status_ff <= olist_pkg::ST_NOTFOUND;
                        state_ff  <= S_EMIT;
                     end else begin
                        status_ff <= olist_pkg::ST_OK;
                        state_ff  <= S_REM_RD;
                     end
                  end
                  default: begin
                     idx_ff    <= '0;
                     status_ff <= olist_pkg::ST_OK;
                     if (count_ff != '0) begin
                        state_ff <= S_DMP_RD;
                     end else begin
                        state_ff <= S_EMIT;
                     end
                  end
               endcase
            end
            S_INS_RD: state_ff <= S_INS_WR;
            S_INS_WR: begin
               // the entry at the insert position was just shifted up out of its slot
               if (CmpW'(idx_ff) == pos_ext) begin
                  state_ff <= S_INS_FIN;
               end else begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= S_INS_RD;
               end
            end
            S_INS_FIN: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_EMIT;
            end
            S_REM_RD: state_ff <= S_REM_CMP;
            S_REM_CMP: begin
               if (rd_data == val_ff) begin
                  if (idx_is_tail) begin
                     count_ff <= count_ff - CW'(1);
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_REM_SRD;
                  end
               end else if (idx_is_tail) begin
                  status_ff <= olist_pkg::ST_NOTFOUND;
                  state_ff  <= S_EMIT;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_REM_RD;
               end
            end
            S_REM_SRD: state_ff <= S_REM_SWR;
            S_REM_SWR: begin
               if (shift_done) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_EMIT;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_REM_SRD;
               end
            end
            S_DMP_RD: state_ff <= S_DMP_EM;
            S_DMP_EM: begin
               // read address holds, so the ram data stays put while waiting
               if (slot_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= olist_pkg::ST_OK;
                  rsp_entry_value_ff <= 32'($unsigned(rd_data));
                  rsp_has_entry_ff   <= 1'b1;
                  rsp_last_ff        <= idx_is_tail;
                  rsp_length_ff      <= 5'(count_ff);
                  if (idx_is_tail) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + CW'(1);
                     state_ff <= S_DMP_RD;
                  end
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= status_ff;
                  rsp_entry_value_ff <= '0;
                  rsp_has_entry_ff   <= 1'b0;
                  rsp_last_ff        <= 1'b1;
                  rsp_length_ff      <= 5'(count_ff);
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_has_entry   = rsp_has_entry_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_length      = rsp_length_ff;

endmodule

/* sv/olist_ram.sv */
// generic single-write, single-read ram with registered read data
module olist_ram #(
   parameter int WIDTH = olist_pkg::DATA_WIDTH_DEFAULT,
   parameter int DEPTH = olist_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/olist_checker.sv */
// port-level checker for the ordered list engine, bound to the engine module
`include "ordered_list_engine_unit_assert.svh"

module olist_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_entry_value,
   input logic               rsp_has_entry,
   input logic               rsp_last,
   input logic [4:0]         rsp_length
);

   // one item in flight: the beat after an accept is always stalled
   `OLIST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input accepted while previous item still in work")

   // status-only beats carry no entry and close their item
   `OLIST_ASSERT_NOW(a_status_beat_shape, clock, reset, rsp_valid && !rsp_has_entry, rsp_last && rsp_entry_value == 32'sd0, "status beat with entry value or without last")

   // dump beats are always ok and come from a non-empty list
   `OLIST_ASSERT_NOW(a_dump_beat_ok, clock, reset, rsp_valid && rsp_has_entry, rsp_status == olist_pkg::ST_OK && rsp_length != 5'd0, "entry beat with bad status or empty length")

   // a stalled result beat holds
   `OLIST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_status) && $stable(rsp_last), "stalled result beat changed")

endmodule

bind ordered_list_engine_unit olist_checker u_olist_checker (.*);

/* tb/tb_top.sv */
// testbench: random and directed list operations checked beat by beat against a list predictor
`timescale 1ns / 100ps

module tb_top;

   localparam int LIST_CAP = olist_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 230;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] value;
      logic [4:0]         position;
   } list_cmd_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic               has_entry;
      logic               last;
      logic [4:0]         length;
   } list_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = olist_pkg::OP_DUMP;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_entry_value;
   logic               rsp_has_entry;
   logic               rsp_last;
   logic [4:0]         rsp_length;

   ordered_list_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_has_entry   (rsp_has_entry),
      .rsp_last        (rsp_last),
      .rsp_length      (rsp_length)
   );

   always #2 clock = ~clock;

   // predicted list contents and pending replies
   logic signed [31:0] shadow_words [LIST_CAP];
   int                 shadow_len = 0;
   list_reply_type     awaited_replies [$];
   list_cmd_type       pending_cmds [$];
   int                 cmds_queued = 0;
   int                 cmds_accepted = 0;
   int                 replies_seen = 0;
   int                 dump_beats = 0;
   int                 status_tally [4] = '{0, 0, 0, 0};
   int                 mismatch_count = 0;

   function automatic void push_reply(logic [1:0] status, logic signed [31:0] value,
                                      logic has, logic last);
      list_reply_type r;
      r.status      = status;
      r.entry_value = value;
      r.has_entry   = has;
      r.last        = last;
      r.length      = 5'(shadow_len);
      awaited_replies.push_back(r);
      status_tally[status]++;
   endfunction

   function automatic void apply_list_op(list_cmd_type c);
      int idx;
      case (c.op)
         olist_pkg::OP_APPEND: begin
            if (shadow_len >= LIST_CAP) begin
               push_reply(olist_pkg::ST_FULL, '0, 1'b0, 1'b1);
            end else begin
               shadow_words[shadow_len] = c.value;
               shadow_len++;
               push_reply(olist_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
         end
         olist_pkg::OP_INSERT: begin
            // a bad position wins over a full list
            if (c.position < 1 || int'(c.position) > shadow_len) begin
               push_reply(olist_pkg::ST_NOPOS, '0, 1'b0, 1'b1);
            end else if (shadow_len >= LIST_CAP) begin
               push_reply(olist_pkg::ST_FULL, '0, 1'b0, 1'b1);
            end else begin
               for (idx = shadow_len; idx > int'(c.position) - 1; idx--)
                  shadow_words[idx] = shadow_words[idx - 1];
               shadow_words[c.position - 1] = c.value;
               shadow_len++;
               push_reply(olist_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
         end
         olist_pkg::OP_REMOVE: begin
            idx = 0;
            while (idx < shadow_len && shadow_words[idx] != c.value)
               idx++;
            if (idx >= shadow_len) begin
               push_reply(olist_pkg::ST_NOTFOUND, '0, 1'b0, 1'b1);
            end else begin
               for (; idx + 1 < shadow_len; idx++)
                  shadow_words[idx] = shadow_words[idx + 1];
               shadow_len--;
               push_reply(olist_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
         end
         default: begin
            if (shadow_len == 0) begin
               push_reply(olist_pkg::ST_OK, '0, 1'b0, 1'b1);
            end else begin
               for (idx = 0; idx < shadow_len; idx++)
                  push_reply(olist_pkg::ST_OK, shadow_words[idx], 1'b1,
                             idx + 1 == shadow_len);
            end
         end
      endcase
   endfunction

   function automatic void queue_cmd(logic [1:0] op, logic signed [31:0] value,
                                     logic [4:0] position);
      list_cmd_type c;
      c.op       = op;
      c.value    = value;
      c.position = position;
      pending_cmds.push_back(c);
      cmds_queued++;
   endfunction

   function automatic void note_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", msg);
   endfunction

   // driver: bursts of beats with random gaps
   list_cmd_type next_cmd;
   logic         req_fire;
   int           burst_left = 0;
   int           gap_left = 0;

   always @(posedge clock) begin
      req_fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire) begin
            next_cmd.op       = req_op;
            next_cmd.value    = req_value;
            next_cmd.position = req_position;
            apply_list_op(next_cmd);
            cmds_accepted++;
         end
         if (!req_valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               next_cmd = pending_cmds.pop_front();
               req_valid    <= 1'b1;
               req_op       <= next_cmd.op;
               req_value    <= next_cmd.value;
               req_position <= next_cmd.position;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                    : $urandom_range(10, 40);
                  gap_left   = $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: own stall pattern, compares each reply beat with the oldest prediction
   list_reply_type want;
   int             stall_mode = 0;
   int             stall_mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (rsp_has_entry === 1'b1)
               dump_beats++;
            if (awaited_replies.size() == 0) begin
               note_error($sformatf({"unexpected beat: status %0d value %0d entry %0b ",
                  "last %0b len %0d"},
                  rsp_status, rsp_entry_value, rsp_has_entry, rsp_last, rsp_length));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status || rsp_entry_value !== want.entry_value ||
                   rsp_has_entry !== want.has_entry || rsp_last !== want.last ||
                   rsp_length !== want.length)
                  note_error($sformatf({"beat %0d: expected status %0d value %0d entry %0b ",
                     "last %0b len %0d, got status %0d value %0d entry %0b last %0b len %0d"},
                     replies_seen, want.status, want.entry_value, want.has_entry, want.last,
                     want.length, rsp_status, rsp_entry_value, rsp_has_entry, rsp_last,
                     rsp_length));
            end
         end
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(10, 80);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            default: rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   // stimulus and end of run
   logic signed [31:0] value_pool [8];
   logic [1:0]         pick_op;
   logic signed [31:0] pick_value;
   logic [4:0]         pick_pos;
   int                 phase_kind;
   int                 roll;

   initial begin
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = -32'sd1;
      value_pool[3] = 32'sd0;
      for (int i = 4; i < 8; i++)
         value_pool[i] = $urandom;

      // empty list corners
      queue_cmd(olist_pkg::OP_DUMP,   32'sd77, 5'd3);
      queue_cmd(olist_pkg::OP_REMOVE, 32'sd5, 5'd0);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd7, 5'd1);
      // value extremes
      queue_cmd(olist_pkg::OP_APPEND, 32'sh8000_0000, 5'd0);
      queue_cmd(olist_pkg::OP_APPEND, 32'sh7fff_ffff, 5'd31);
      queue_cmd(olist_pkg::OP_APPEND, 32'sd0, 5'd0);
      queue_cmd(olist_pkg::OP_APPEND, -32'sd1, 5'd0);
      // insert positions: zero, far out, head, just before tail
      queue_cmd(olist_pkg::OP_INSERT, 32'sd9, 5'd0);
      queue_cmd(olist_pkg::OP_INSERT, 32'shaaaa_aaaa, 5'd31);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd3, 5'd1);
      queue_cmd(olist_pkg::OP_INSERT, 32'sh5555_5555, 5'd5);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd11, 5'd7);
      queue_cmd(olist_pkg::OP_DUMP,   32'sd0, 5'd0);
      // remove middle, tail, miss, then first of two duplicates
      queue_cmd(olist_pkg::OP_REMOVE, 32'sd0, 5'd0);
      queue_cmd(olist_pkg::OP_REMOVE, -32'sd1, 5'd0);
      queue_cmd(olist_pkg::OP_REMOVE, 32'sd1234, 5'd0);
      queue_cmd(olist_pkg::OP_APPEND, 32'sd3, 5'd0);
      queue_cmd(olist_pkg::OP_REMOVE, 32'sd3, 5'd0);
      queue_cmd(olist_pkg::OP_DUMP,   32'sd0, 5'd0);

      // fill to capacity, then the full-list cases
      repeat (LIST_CAP - 4)
         queue_cmd(olist_pkg::OP_APPEND, value_pool[$urandom_range(0, 7)],
                   5'($urandom_range(0, 31)));
      queue_cmd(olist_pkg::OP_APPEND, 32'sd42, 5'd0);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd42, 5'd16);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd42, 5'd17);
      queue_cmd(olist_pkg::OP_INSERT, 32'sd42, 5'd0);
      queue_cmd(olist_pkg::OP_DUMP,   32'sd0, 5'd0);

      // random phases: growing, shrinking, mixed; values mostly from a small pool
      while (cmds_queued < RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 2);
         repeat ($urandom_range(15, 35)) begin
            if (cmds_queued >= RANDOM_ITEMS)
               break;
            roll = $urandom_range(0, 99);
            case (phase_kind)
               0:       pick_op = roll < 55 ? olist_pkg::OP_APPEND :
                                  roll < 80 ? olist_pkg::OP_INSERT :
                                  roll < 88 ? olist_pkg::OP_REMOVE : olist_pkg::OP_DUMP;
               1:       pick_op = roll < 15 ? olist_pkg::OP_APPEND :
                                  roll < 25 ? olist_pkg::OP_INSERT :
                                  roll < 80 ? olist_pkg::OP_REMOVE : olist_pkg::OP_DUMP;
               default: pick_op = roll < 30 ? olist_pkg::OP_APPEND :
                                  roll < 55 ? olist_pkg::OP_INSERT :
                                  roll < 85 ? olist_pkg::OP_REMOVE : olist_pkg::OP_DUMP;
            endcase
            pick_value = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, 7)]
                                                      : $urandom;
            pick_pos   = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 17))
                                                      : 5'($urandom_range(0, 31));
            queue_cmd(pick_op, pick_value, pick_pos);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (cmds_accepted < cmds_queued) @(negedge clock);
      while (awaited_replies.size() > 0) @(negedge clock);
      // longest item is a dump of a full list plus a shift walk, with stalls
      repeat (200) @(negedge clock);

      $display("ran %0d list operations giving %0d reply beats, %0d of them dump entries",
               cmds_accepted, replies_seen, dump_beats);
      $display("status mix: ok %0d, bad position %0d, not found %0d, list full %0d",
               status_tally[olist_pkg::ST_OK], status_tally[olist_pkg::ST_NOPOS],
               status_tally[olist_pkg::ST_NOTFOUND], status_tally[olist_pkg::ST_FULL]);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d of %0d operations accepted, %0d beats outstanding",
               cmds_accepted, cmds_queued, awaited_replies.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/olist_pkg.sv
sv/olist_ram.sv
sv/ordered_list_engine_unit.sv
sv/olist_checker.sv
tb/tb_top.sv
